FILE: rtl/core/lfrc_pkg.sv
// Shared types, mode codes and drive helpers for the line follower route controller.
`timescale 1ns / 1ps

package lfrc_pkg;

	// Mode codes
	localparam logic [2:0] MODE_FOLLOW = 3'd0;
	localparam logic [2:0] MODE_SPIN_L = 3'd1;
	localparam logic [2:0] MODE_SPIN_R = 3'd2;
	localparam logic [2:0] MODE_ALIGN  = 3'd3;
	localparam logic [2:0] MODE_CROSS  = 3'd4;

	// Route action codes
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_LEFT  = 2'd1;
	localparam logic [1:0] ACT_RIGHT = 2'd2;
	localparam logic [1:0] ACT_CROSS = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_ROUTE_ACTIONS = 2'd0;
	localparam logic [1:0] REG_ROUTE_LENGTH  = 2'd1;
	localparam logic [1:0] REG_ALIGN_TICKS   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [31:0] ROUTE_ACTIONS_RST = 32'd976311;
	localparam logic [4:0]  ROUTE_LENGTH_RST  = 5'd10;
	localparam logic [15:0] ALIGN_TICKS_RST   = 16'd1000;

	// Drive image masks and bits
	localparam logic [7:0] DRV_KEEP_MASK = 8'hCF & 8'h3F & 8'hF9;
	localparam logic [7:0] DRV_STOP_MASK = 8'hCF;
	localparam logic [7:0] DRV_EN        = 8'h30;
	localparam logic [7:0] DRV_A_FWD     = 8'h80;
	localparam logic [7:0] DRV_A_REV     = 8'h40;
	localparam logic [7:0] DRV_B_FWD     = 8'h02;
	localparam logic [7:0] DRV_B_REV     = 8'h04;

	// Result beat layout
	typedef struct packed {
		logic [2:0] current_mode;
		logic [4:0] route_position;
		logic       junction_seen;
		logic [7:0] motor_port;
	} result_t;

	function automatic logic [7:0] drv_front(input logic [7:0] d);
		return (d & DRV_KEEP_MASK) | DRV_A_FWD | DRV_B_FWD | DRV_EN;
	endfunction

	function automatic logic [7:0] drv_soft_right(input logic [7:0] d);
		return (d & DRV_KEEP_MASK) | DRV_B_FWD | DRV_EN;
	endfunction

	function automatic logic [7:0] drv_soft_left(input logic [7:0] d);
		return (d & DRV_KEEP_MASK) | DRV_A_FWD | DRV_EN;
	endfunction

	function automatic logic [7:0] drv_spin_right(input logic [7:0] d);
		return (d & DRV_KEEP_MASK) | DRV_A_REV | DRV_B_FWD | DRV_EN;
	endfunction

	function automatic logic [7:0] drv_spin_left(input logic [7:0] d);
		return (d & DRV_KEEP_MASK) | DRV_A_FWD | DRV_B_REV | DRV_EN;
	endfunction

	// Steering on sensors 1 and 7 (1 white); both black keeps the drive
	function automatic logic [7:0] steer(input logic [8:0] s, input logic [7:0] d);
		logic [7:0] r;
		r = d;
		if (s[1] && s[7]) begin
			r = drv_front(d);
		end else if (!s[1] && s[7]) begin
			r = drv_soft_right(d);
		end else if (s[1] && !s[7]) begin
			r = drv_soft_left(d);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/line_follower_route_controller_top.sv
// Line follower route controller: mode update per sensor beat with a two-entry result buffer.
`timescale 1ns / 1ps

// Channel  | Dir | Payload (low bit first)                                   | Handshake
// s_axis   | in  | s_tdata: sensor_bits[8:0], zero pad to 16                  | s_tvalid/s_tready
// m_axis   | out | m_tdata: motor_port[7:0], junction_seen, route_position[4:0],
//          |     |          current_mode[2:0], zero pad to 24                 | m_tvalid/m_tready
// cfg      | in  | cfg_index selects register, cfg_wdata[31:0]                | cfg_we, no wait
//
// One beat in, one beat out. Each sample is decoded and the mode state updated in the
// cycle it is accepted; its result is registered in the output or the skid entry.
// One beat per clock while m_tready is high; the two-entry output buffer lets s_tready
// stay high while one result waits. s_tready drops only when both entries hold results.
// arst_n clears mode, route index, align count, drive image and valid flags; presets cfg.

module line_follower_route_controller_top
	import lfrc_pkg::*;
#(
	parameter int ROUTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// sensor beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sensor_bits[8:0]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // motor_port[7:0], junction_seen, route_position[4:0],
	                               // current_mode[2:0]
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	localparam logic [4:0] DEPTH_LIM = 5'(ROUTE_DEPTH);

	logic [31:0] route_actions_q;
	logic [4:0]  route_length_q;
	logic [15:0] align_ticks_q;

	logic [2:0]  mode_q, mode_n;
	logic [4:0]  idx_q, idx_n;
	logic [15:0] cnt_q, cnt_n, cnt_inc;
	logic [7:0]  drv_q, drv_n;
	logic        junc;
	logic [8:0]  sens;
	logic        side_white, right_side, left_side, finish;
	logic [4:0]  limit;
	logic [31:0] act_word;
	logic [1:0]  act;

	result_t     res, out_q, skid_q;
	logic        out_v_q, skid_v_q;
	logic        push, pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_actions_q <= ROUTE_ACTIONS_RST;
			route_length_q  <= ROUTE_LENGTH_RST;
			align_ticks_q   <= ALIGN_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROUTE_ACTIONS: route_actions_q <= cfg_wdata;
				REG_ROUTE_LENGTH:  route_length_q  <= cfg_wdata[4:0];
				REG_ALIGN_TICKS:   align_ticks_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign sens       = s_tdata[8:0];
	assign right_side = (sens[4:0] == 5'd0) && sens[8];
	assign left_side  = (sens[8:4] == 5'd0) && sens[0];
	assign limit      = (route_length_q < DEPTH_LIM) ? route_length_q : DEPTH_LIM;
	assign act_word   = route_actions_q >> {idx_q[3:0], 1'b0};
	assign act        = act_word[1:0];
	assign cnt_inc    = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;

	// Next state for one sample
	always_comb begin
		mode_n     = mode_q;
		idx_n      = idx_q;
		cnt_n      = cnt_q;
		drv_n      = drv_q;
		junc       = 1'b0;
		finish     = 1'b0;
		side_white = (mode_q == MODE_SPIN_L) ? (&sens[8:4]) : (&sens[4:0]);
		case (mode_q)
			MODE_SPIN_L, MODE_SPIN_R: begin
				if (!side_white) begin
					drv_n = (mode_q == MODE_SPIN_L) ? drv_spin_left(drv_q)
					                                : drv_spin_right(drv_q);
				end else if (align_ticks_q == 16'd0) begin
					finish = 1'b1;
				end else begin
					cnt_n  = 16'd0;
					mode_n = MODE_ALIGN;
				end
			end
			MODE_ALIGN: begin
				drv_n = steer(sens, drv_q);
				cnt_n = cnt_inc;
				if (cnt_inc >= align_ticks_q) begin
					finish = 1'b1;
				end
			end
			MODE_CROSS: begin
				if (!sens[0] || !sens[8]) begin
					drv_n = drv_front(drv_q);
				end else begin
					finish = 1'b1;
				end
			end
			default: begin
				// follow: junction check, then route action or steering
				mode_n = MODE_FOLLOW;
				drv_n  = steer(sens, drv_q);
				if (right_side || left_side) begin
					junc = 1'b1;
					if (idx_q < limit) begin
						case (act)
							ACT_LEFT: begin
								mode_n = MODE_SPIN_L;
								drv_n  = drv_q;
							end
							ACT_RIGHT: begin
								mode_n = MODE_SPIN_R;
								drv_n  = drv_q;
							end
							ACT_CROSS: begin
								mode_n = MODE_CROSS;
								drv_n  = drv_q;
							end
							default: idx_n = idx_q + 5'd1;
						endcase
					end
				end
			end
		endcase
		// end of an action: stop, consume the entry, back to follow
		if (finish) begin
			drv_n  = drv_n & DRV_STOP_MASK;
			idx_n  = (idx_q != 5'd31) ? idx_q + 5'd1 : idx_q;
			mode_n = MODE_FOLLOW;
		end
	end

	assign res.motor_port     = drv_n;
	assign res.junction_seen  = junc;
	assign res.route_position = idx_n;
	assign res.current_mode   = mode_n;

	assign s_tready = !skid_v_q;
	assign push     = s_tvalid && s_tready;
	assign pop      = out_v_q && m_tready;

	// Mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FOLLOW;
			idx_q  <= 5'd0;
			cnt_q  <= 16'd0;
			drv_q  <= 8'd0;
		end else if (push) begin
			mode_q <= mode_n;
			idx_q  <= idx_n;
			cnt_q  <= cnt_n;
			drv_q  <= drv_n;
		end
	end

	// Output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	// Buffer payloads
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_q};

endmodule

FILE: rtl/core/lfrc_checker.sv
// Port-level checks for the line follower route controller, bound to the top level.
`timescale 1ns / 1ps

module lfrc_checker
	import lfrc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// input backpressure only with a result waiting
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("s_tready low with empty output");

	// a junction is seen only in follow, so the mode after it is never align
	a_junc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tdata[16:14] != MODE_ALIGN)
		else $error("junction reported leading into align");

	// an accepted beat always leaves a result valid on the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

endmodule

bind line_follower_route_controller_top lfrc_checker u_lfrc_checker (.*);
